@@ hw/rtl/csdt_pkg.sv @@
// package for the clause scoreboard dependency tracker
// holds op codes, fixed field widths, parameter defaults and slot control and status types
// no dependencies
`timescale 1ns / 1ps

package csdt_pkg;

	localparam int OP_W   = 2;
	localparam int MASK_W = 64;
	localparam int SLOT_W = 3;
	localparam int DEP_W  = 8;

	localparam logic [OP_W-1:0] OP_INSTR      = 2'd0;
	localparam logic [OP_W-1:0] OP_CLAUSE_END = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

	localparam int SERIAL_SLOT = 0;

	localparam int NUM_SLOTS_DEF     = 8;
	localparam int NUM_REGISTERS_DEF = 64;
	localparam int GENERAL_SLOTS_DEF = 6;

	typedef struct packed {
		logic instr;
		logic wipe;
		logic rec_read;
		logic rec_write;
	} slot_cmd_t;

	typedef struct packed {
		logic dep_hit;
		logic bar_hit;
	} slot_stat_t;

endpackage

@@ hw/rtl/clause_scoreboard_dependency_tracker_unit.sv @@
// top level of the clause scoreboard dependency tracker
// depends on csdt_pkg and csdt_slot
`timescale 1ns / 1ps

// Usage:
// in channel (in_valid/in_ready) carries one word per instruction, clause end
// or clear item. out channel (out_valid/out_ready) carries one word per clause
// end: the slots the clause waits on and the staging hazard flag.
// cfg channel (cfg_valid/cfg_ready, cfg_data) writes serialize_all; cfg_ready
// is always high and the register is meant to change only while idle.
// An item taken in is checked against all slots in the following cycle,
// from the input stage register; a clause-end result goes from the input
// stage into the output register and then shows on out_valid. One word per
// cycle while no result is stalled; every slot compares in parallel.
// A result waits in the output register while out_ready is low; a clause end
// behind it then holds in the input stage and in_ready drops. Instruction and
// clear words keep flowing past a stalled result.
// Reset clears all slot sets, pending dependencies, the barrier flag and
// serialize_all; the block takes words in the first cycle after reset.
module clause_scoreboard_dependency_tracker_unit #(
	parameter int NUM_SLOTS     = csdt_pkg::NUM_SLOTS_DEF,
	parameter int NUM_REGISTERS = csdt_pkg::NUM_REGISTERS_DEF,
	parameter int GENERAL_SLOTS = csdt_pkg::GENERAL_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [csdt_pkg::OP_W-1:0]    op,
	input  logic [csdt_pkg::MASK_W-1:0]  read_mask,
	input  logic [csdt_pkg::MASK_W-1:0]  write_mask,
	input  logic                         has_message,
	input  logic [csdt_pkg::SLOT_W-1:0]  slot,
	input  logic [csdt_pkg::MASK_W-1:0]  staging_read_mask,
	input  logic                         records_writes,
	input  logic                         serialize,
	input  logic                         is_barrier,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [csdt_pkg::DEP_W-1:0]   dependencies,
	output logic                         staging_hazard,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data
);

	localparam int DW = csdt_pkg::DEP_W;

	// input stage
	logic                              valid_s1;
	logic [csdt_pkg::OP_W-1:0]         op_s1;
	logic [NUM_REGISTERS-1:0]          rd_s1;
	logic [NUM_REGISTERS-1:0]          wr_s1;
	logic                              msg_s1;
	logic [csdt_pkg::SLOT_W-1:0]       slot_s1;
	logic [NUM_REGISTERS-1:0]          stg_s1;
	logic                              recw_s1;
	logic                              ser_s1;
	logic                              bar_s1;

	logic                              serialize_all_q;
	logic [DW-1:0]                     pend_dep_q;
	logic                              pend_bar_q;
	logic                              out_valid_q;
	logic [DW-1:0]                     dep_q;
	logic                              sbar_q;

	logic                              is_instr;
	logic                              is_end;
	logic                              is_clear;
	logic                              out_free;
	logic                              adv;
	logic                              end_adv;

	csdt_pkg::slot_cmd_t               cmd  [NUM_SLOTS];
	csdt_pkg::slot_stat_t              stat [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]              bar_hits;
	logic [DW-1:0]                     dep_hits;
	logic [DW-1:0]                     gen_mask;
	logic [DW-1:0]                     extra_dep;

	assign is_instr = (op_s1 == csdt_pkg::OP_INSTR);
	assign is_end   = (op_s1 == csdt_pkg::OP_CLAUSE_END);
	assign is_clear = (op_s1 == csdt_pkg::OP_CLEAR);

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!is_end || out_free);
	assign end_adv  = adv && is_end;
	assign in_ready = !valid_s1 || adv;

	assign cfg_ready = 1'b1;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
		assign cmd[i].instr     = adv && is_instr;
		assign cmd[i].wipe      = adv && is_clear;
		assign cmd[i].rec_read  = end_adv && msg_s1 && (32'(slot_s1) == i);
		assign cmd[i].rec_write = end_adv && msg_s1 && recw_s1 && (32'(slot_s1) == i);
		assign bar_hits[i]      = stat[i].bar_hit;

		csdt_slot #(
			.NUM_REGISTERS(NUM_REGISTERS)
		) u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[i]),
			.rd     (rd_s1),
			.wr     (wr_s1),
			.staging(stg_s1),
			.stat   (stat[i])
		);
	end

	// slots above the output width are dropped
	for (genvar i = 0; i < DW; i++) begin : g_dep
		if (i < NUM_SLOTS) begin : g_in
			assign dep_hits[i] = stat[i].dep_hit;
		end else begin : g_out
			assign dep_hits[i] = 1'b0;
		end
		assign gen_mask[i] = (i < GENERAL_SLOTS);
	end

	always_comb begin
		extra_dep = '0;
		if (msg_s1) begin
			if (ser_s1 || serialize_all_q) begin
				extra_dep[csdt_pkg::SERIAL_SLOT] = 1'b1;
			end
			if (bar_s1) begin
				extra_dep = extra_dep | gen_mask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serialize_all_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			serialize_all_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			rd_s1   <= read_mask[NUM_REGISTERS-1:0];
			wr_s1   <= write_mask[NUM_REGISTERS-1:0];
			msg_s1  <= has_message;
			slot_s1 <= slot;
			stg_s1  <= staging_read_mask[NUM_REGISTERS-1:0];
			recw_s1 <= records_writes;
			ser_s1  <= serialize;
			bar_s1  <= is_barrier;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_dep_q <= '0;
			pend_bar_q <= 1'b0;
		end else if (adv && is_instr) begin
			pend_dep_q <= pend_dep_q | dep_hits;
			pend_bar_q <= pend_bar_q | (|bar_hits);
		end else if (end_adv) begin
			pend_dep_q <= '0;
			pend_bar_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_adv) begin
			dep_q  <= pend_dep_q | extra_dep;
			sbar_q <= pend_bar_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign dependencies   = dep_q;
	assign staging_hazard = sbar_q;

	a_end_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		end_adv |=> (pend_dep_q == '0) && !pend_bar_q)
		else $error("pending state kept after clause end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && is_end && out_valid_q && !out_ready)
		else $error("input stalled without a blocked clause end");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(end_adv))
		else $error("result raised without a clause end");

endmodule

@@ hw/rtl/csdt_slot.sv @@
// one dependency slot: staging read set and write set with hazard checks
// depends on csdt_pkg
`timescale 1ns / 1ps

module csdt_slot #(
	parameter int NUM_REGISTERS = csdt_pkg::NUM_REGISTERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  csdt_pkg::slot_cmd_t      cmd,
	input  logic [NUM_REGISTERS-1:0] rd,
	input  logic [NUM_REGISTERS-1:0] wr,
	input  logic [NUM_REGISTERS-1:0] staging,
	output csdt_pkg::slot_stat_t     stat
);

	logic [NUM_REGISTERS-1:0] rset_q;
	logic [NUM_REGISTERS-1:0] wset_q;
	logic                     w_hit;
	logic                     r_hit;

	assign w_hit = |(wset_q & (rd | wr));
	// a slot emptied by a write hit has no read set left to conflict
	assign r_hit = !w_hit && (|(rset_q & wr));

	assign stat.dep_hit = cmd.instr && w_hit;
	assign stat.bar_hit = cmd.instr && r_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rset_q <= '0;
			wset_q <= '0;
		end else if (cmd.wipe) begin
			rset_q <= '0;
			wset_q <= '0;
		end else if (cmd.instr) begin
			if (w_hit) begin
				rset_q <= '0;
				wset_q <= '0;
			end else if (r_hit) begin
				rset_q <= '0;
			end
		end else if (cmd.rec_read) begin
			rset_q <= rset_q | staging;
			if (cmd.rec_write) begin
				wset_q <= wset_q | wr;
			end
		end
	end

	a_wipe_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wipe |=> (rset_q == '0) && (wset_q == '0))
		else $error("slot not empty after clear");

	a_dep_empties: assert property (@(posedge clk) disable iff (!arst_n)
		stat.dep_hit && !cmd.wipe |=> (rset_q == '0) && (wset_q == '0))
		else $error("slot not emptied after write hit");

endmodule
